// ----- src/spd_pkg.sv -----
// ----------------------------------------------------------------------------
// spd_pkg
// shared types and constants for the sequence checked packet deframer
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int unsigned LEN_W = 24;
    localparam int unsigned SEQ_W = 8;
    localparam int unsigned BYTE_W = 8;

    localparam logic [LEN_W-1:0] LEN_CONTINUE = {LEN_W{1'b1}};

    typedef enum logic [0:0] {
        CMD_BYTE    = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        ERR_OK       = 1'b0,
        ERR_SEQUENCE = 1'b1
    } t_err;

    // 0..2 length bytes, 3 sequence byte, 4 payload
    typedef enum logic [2:0] {
        HDR_LEN0    = 3'd0,
        HDR_LEN1    = 3'd1,
        HDR_LEN2    = 3'd2,
        HDR_SEQ     = 3'd3,
        HDR_PAYLOAD = 3'd4
    } t_hdr;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_data;
        logic              last_of_message;
        t_err              error_code;
    } t_result;

endpackage

// ----- src/seq_checked_packet_deframer_core.sv -----
// output: a result is registered in the output register, or in the skid stage
// throughput: one input byte per cycle; a two-entry output register and skid
// stage let input continue while a result waits, stall rises only when both hold
// reset: synchronous active low; framing restarts at the first length byte,
// expected sequence is zero and the error lock is clear
// ----------------------------------------------------------------------------
// seq_checked_packet_deframer_core
// splits a length prefixed byte stream into payload bytes with message end
// markers and sequence number checking
// ----------------------------------------------------------------------------
module seq_checked_packet_deframer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_command,
    input  logic [spd_pkg::BYTE_W-1:0] i_in_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [spd_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_has_data,
    output logic                       o_last_of_message,
    output logic                       o_error_code
);
    import spd_pkg::*;

    t_hdr             r_hdr, n_hdr;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [SEQ_W-1:0] r_exp_seq, n_exp_seq;
    logic             r_cont, n_cont;
    logic             r_err_lock, n_err_lock;

    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;

    logic             accept;
    logic             out_take;
    logic             gen;
    t_result          res;
    logic [LEN_W-1:0] pos_inc;
    t_cmd             cmd;

    assign cmd      = t_cmd'(i_command);
    assign accept   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;
    assign pos_inc  = r_pos + LEN_W'(1);

    // next framing state
    always_comb begin
        n_hdr      = r_hdr;
        n_len      = r_len;
        n_pos      = r_pos;
        n_exp_seq  = r_exp_seq;
        n_cont     = r_cont;
        n_err_lock = r_err_lock;
        if (accept) begin
            if (cmd == CMD_RESTART) begin
                n_hdr      = HDR_LEN0;
                n_len      = '0;
                n_pos      = '0;
                n_cont     = 1'b0;
                n_exp_seq  = '0;
                n_err_lock = 1'b0;
            end else if (!r_err_lock) begin
                unique case (r_hdr)
                    HDR_LEN1: begin
                        n_len[15:8] = i_in_byte;
                        n_hdr       = HDR_LEN2;
                    end
                    HDR_LEN2: begin
                        n_len[23:16] = i_in_byte;
                        n_hdr        = HDR_SEQ;
                    end
                    HDR_SEQ: begin
                        if (i_in_byte != r_exp_seq) begin
                            n_err_lock = 1'b1;
                            n_hdr      = HDR_LEN0;
                            n_len      = '0;
                            n_pos      = '0;
                            n_cont     = 1'b0;
                        end else begin
                            n_exp_seq = r_exp_seq + SEQ_W'(1);
                            n_cont    = (r_len == LEN_CONTINUE);
                            n_pos     = '0;
                            n_hdr     = (r_len == '0) ? HDR_LEN0 : HDR_PAYLOAD;
                        end
                    end
                    HDR_PAYLOAD: begin
                        n_pos = pos_inc;
                        if (pos_inc == r_len) begin
                            n_hdr = HDR_LEN0;
                        end
                    end
                    default: begin
                        // first length byte, and any unused index
                        n_len = {{(LEN_W-BYTE_W){1'b0}}, i_in_byte};
                        n_hdr = HDR_LEN1;
                    end
                endcase
            end
        end
    end

    // result of the current transfer
    always_comb begin
        gen = 1'b0;
        res = '{out_byte: '0, has_data: 1'b0, last_of_message: 1'b0,
                error_code: ERR_OK};
        if (accept && cmd == CMD_BYTE && !r_err_lock) begin
            unique case (r_hdr)
                HDR_SEQ: begin
                    if (i_in_byte != r_exp_seq) begin
                        gen            = 1'b1;
                        res.error_code = ERR_SEQUENCE;
                    end else if (r_len == '0) begin
                        gen                 = 1'b1;
                        res.last_of_message = 1'b1;
                    end
                end
                HDR_PAYLOAD: begin
                    gen                 = 1'b1;
                    res.out_byte        = i_in_byte;
                    res.has_data        = 1'b1;
                    res.last_of_message = (pos_inc == r_len) && !r_cont;
                end
                default: begin
                    gen = 1'b0;
                end
            endcase
        end
    end

    // output register with skid stage
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (gen) begin
            if (!r_out_valid || out_take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr        <= HDR_LEN0;
            r_len        <= '0;
            r_pos        <= '0;
            r_exp_seq    <= '0;
            r_cont       <= 1'b0;
            r_err_lock   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_hdr        <= n_hdr;
            r_len        <= n_len;
            r_pos        <= n_pos;
            r_exp_seq    <= n_exp_seq;
            r_cont       <= n_cont;
            r_err_lock   <= n_err_lock;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall        = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out.out_byte;
    assign o_has_data        = r_out.has_data;
    assign o_last_of_message = r_out.last_of_message;
    assign o_error_code      = r_out.error_code;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_payload_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr == HDR_PAYLOAD |-> r_len != '0)
        else $error("payload phase with zero length");

    a_payload_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr == HDR_PAYLOAD |-> r_pos < r_len)
        else $error("payload position ran past length");

    a_lock_framing_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_lock |-> r_hdr == HDR_LEN0)
        else $error("framing active while error lock set");

    a_error_marker_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code == ERR_SEQUENCE)
            |-> (!r_out.has_data && !r_out.last_of_message))
        else $error("error result carries data or end marker");
`endif

endmodule
